### design/alp_pkg.sv
package alp_pkg;

  localparam int POOL_ENTRIES = 256;
  localparam int IDX_W = $clog2(POOL_ENTRIES);
  localparam int LIM_W = (IDX_W + 1 > 9) ? IDX_W + 1 : 9;

  localparam logic [31:0] BASE_ADDRESS_RST = 32'hC0A8_0102;
  localparam logic [31:0] LEASE_EXTEND_RST = 32'd86400;
  localparam logic [31:0] EXPIRY_WINDOW_RST = 32'd43200;
  localparam logic [8:0] ALLOC_LIMIT_RST = 9'd254;

  typedef enum logic [1:0] {
    REG_BASE_ADDRESS = 2'd0,
    REG_LEASE_EXTEND = 2'd1,
    REG_EXPIRY_WINDOW = 2'd2,
    REG_ALLOC_LIMIT = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    STAT_FREE = 2'd0,
    STAT_TAKEN = 2'd1,
    STAT_PROG = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OC_RENEW = 2'd0,
    OC_NEW = 2'd1,
    OC_FULL = 2'd2,
    OC_SWEPT = 2'd3
  } outcome_t;

  typedef enum logic {
    FN_REQUEST = 1'b0,
    FN_SWEEP = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ALLOC,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [0:0] func;
    logic [47:0] client_mac;
    logic [31:0] now_seconds;
  } in_word_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [7:0] entry_index;
    logic [31:0] lease_address;
    logic [8:0] freed_count;
  } out_word_t;

  typedef struct packed {
    logic [31:0] base_address;
    logic [31:0] lease_extend;
    logic [31:0] expiry_window;
    logic [8:0] alloc_limit;
  } cfg_t;

  typedef struct packed {
    status_t status;
    logic [47:0] client;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic we;
    logic [IDX_W-1:0] waddr;
    entry_t wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

### design/alp_mem.sv
module alp_mem
  import alp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mem_req_t req,
  output entry_t   rdata
);

  entry_t mem [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] valid;
  entry_t rd_q;
  logic rd_valid;

  // entry array, no reset
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_q <= mem[req.raddr];
  end

  // written-entry flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
      rd_valid <= valid[req.raddr];
    end
  end

  always_comb begin
    rdata = rd_q;
    if (!rd_valid) begin
      rdata.status = STAT_FREE;
    end
  end

endmodule

### design/alp_ctrl.sv
module alp_ctrl
  import alp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      in_valid,
  input  in_word_t  in_word,
  output logic      busy,
  output logic      res_valid,
  input  logic      res_take,
  output out_word_t res_word,
  output mem_req_t  mem_req,
  input  entry_t    mem_rdata
);

  state_t state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  func_t func;
  logic [47:0] mac;
  logic [31:0] now;
  logic have_free, have_free_next;
  logic [IDX_W-1:0] free_idx, free_idx_next;
  logic [8:0] freed, freed_next;
  out_word_t res, res_next;

  logic is_free;
  logic last;
  logic hit;
  logic below_limit;
  logic due;
  logic [32:0] due_sum;
  logic [31:0] addr_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    have_free <= have_free_next;
    free_idx <= free_idx_next;
    freed <= freed_next;
    res <= res_next;
    if (state == S_IDLE && in_valid) begin
      func <= func_t'(in_word.func);
      mac <= in_word.client_mac;
      now <= in_word.now_seconds;
    end
  end

  assign is_free = (mem_rdata.status == STAT_FREE);
  assign last = (idx == IDX_W'(POOL_ENTRIES - 1));
  assign hit = !is_free && (mem_rdata.client == mac);
  assign below_limit = (LIM_W'(idx) < LIM_W'(cfg.alloc_limit));
  assign due_sum = {1'b0, mem_rdata.stamp} + {1'b0, cfg.expiry_window};
  assign due = (due_sum <= {1'b0, now});
  assign addr_sum = cfg.base_address + 32'(state == S_ALLOC ? free_idx : idx);

  assign busy = (state != S_IDLE);
  assign res_valid = (state == S_EMIT);
  assign res_word = res;

  always_comb begin
    state_next = state;
    idx_next = idx;
    have_free_next = have_free;
    free_idx_next = free_idx;
    freed_next = freed;
    res_next = res;
    mem_req.we = 1'b0;
    mem_req.waddr = idx;
    mem_req.wdata = mem_rdata;
    mem_req.raddr = idx + IDX_W'(1);

    unique case (state)
      S_IDLE: begin
        mem_req.raddr = '0;
        if (in_valid) begin
          idx_next = '0;
          have_free_next = 1'b0;
          freed_next = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        idx_next = idx + IDX_W'(1);
        if (func == FN_SWEEP) begin
          if (!is_free && due) begin
            mem_req.we = 1'b1;
            mem_req.wdata.status = STAT_FREE;
            if (freed != 9'h1FF) begin
              freed_next = freed + 9'd1;
            end
          end
          if (last) begin
            res_next.outcome = OC_SWEPT;
            res_next.entry_index = '0;
            res_next.lease_address = '0;
            res_next.freed_count = freed_next;
            state_next = S_EMIT;
          end
        end else if (hit) begin
          mem_req.we = 1'b1;
          mem_req.wdata.status = STAT_TAKEN;
          mem_req.wdata.stamp = mem_rdata.stamp + cfg.lease_extend;
          res_next.outcome = OC_RENEW;
          res_next.entry_index = 8'(idx);
          res_next.lease_address = addr_sum;
          res_next.freed_count = '0;
          state_next = S_EMIT;
        end else begin
          if (is_free && below_limit && !have_free) begin
            have_free_next = 1'b1;
            free_idx_next = idx;
          end
          if (last) begin
            if (have_free_next) begin
              state_next = S_ALLOC;
            end else begin
              res_next.outcome = OC_FULL;
              res_next.entry_index = '0;
              res_next.lease_address = '0;
              res_next.freed_count = '0;
              state_next = S_EMIT;
            end
          end
        end
      end
      S_ALLOC: begin
        mem_req.we = 1'b1;
        mem_req.waddr = free_idx;
        mem_req.wdata.status = STAT_PROG;
        mem_req.wdata.client = mac;
        mem_req.wdata.stamp = now;
        res_next.outcome = OC_NEW;
        res_next.entry_index = 8'(free_idx);
        res_next.lease_address = addr_sum;
        res_next.freed_count = '0;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/address_lease_pool.sv
// sequence: a sweep or a full-pool miss scans every entry and then emits its result;
// a renewal emits at the first hit, and a new allocation writes its entry in S_ALLOC after the scan
// throughput: a new word waits until the last result is taken; the scan uses the single
// entry-memory read port, one entry per cycle
// reset: config registers return to defaults and all entries read as free at once
module address_lease_pool
  import alp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_word
);

  cfg_t cfg;
  logic busy;
  logic res_valid;
  logic res_take;
  out_word_t res_word;
  mem_req_t mem_req;
  entry_t mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address <= BASE_ADDRESS_RST;
      cfg.lease_extend <= LEASE_EXTEND_RST;
      cfg.expiry_window <= EXPIRY_WINDOW_RST;
      cfg.alloc_limit <= ALLOC_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_BASE_ADDRESS: cfg.base_address <= cfg_data;
        REG_LEASE_EXTEND: cfg.lease_extend <= cfg_data;
        REG_EXPIRY_WINDOW: cfg.expiry_window <= cfg_data;
        REG_ALLOC_LIMIT: cfg.alloc_limit <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = busy;
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_word <= res_word;
    end
  end

  alp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .busy      (busy),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_word  (res_word),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  alp_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule
